// ----- hdl/prt_pkg.sv -----
`default_nettype none

package prt_pkg;

  localparam int unsigned SLOW_CLOCK_DIVIDE_DEFAULT = 8;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CTRL_W     = 7;
  localparam int unsigned PRESCALE_W = 9;
  localparam int unsigned EXP_W      = 3;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // register words in the window
  localparam logic [1:0] WORD_CTRL  = 2'd0;
  localparam logic [1:0] WORD_LOAD  = 2'd1;
  localparam logic [1:0] WORD_COUNT = 2'd2;

  localparam logic [2:0] ACCESS_SIZE_WORD = 3'd4;

  // control register bits
  localparam int unsigned CTRL_START_BIT  = 0;
  localparam int unsigned CTRL_RELOAD_BIT = 1;
  localparam int unsigned CTRL_EXP_LSB    = 2;

  // configuration register indexes
  localparam logic CFG_CPU_SPEED    = 1'b0;
  localparam logic CFG_IRQ_CONNECTED = 1'b1;

  typedef struct packed {
    logic [1:0]        action;
    logic [3:0]        address_offset;
    logic [2:0]        access_size;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              access_ok;
    logic              irq_pulse;
  } result_t;

  typedef struct packed {
    logic cpu_speed;
    logic irq_connected;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/prt_stream_if.sv -----
`default_nettype none

interface prt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/prt_core.sv -----
`default_nettype none

module prt_core #(
  parameter int unsigned SLOW_CLOCK_DIVIDE = prt_pkg::SLOW_CLOCK_DIVIDE_DEFAULT
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire prt_pkg::item_t item_i,
  input  wire prt_pkg::cfg_t  cfg_i,
  output prt_pkg::result_t    result_o
);

  localparam int unsigned DivW = $clog2(SLOW_CLOCK_DIVIDE + 1);

  logic [prt_pkg::CTRL_W-1:0]     ctrl_q, ctrl_d;
  logic [prt_pkg::DATA_W-1:0]     count_q, count_d;
  logic [prt_pkg::DATA_W-1:0]     load_q, load_d;
  logic [prt_pkg::PRESCALE_W-1:0] pre_q, pre_d;
  logic [DivW-1:0]                div_q, div_d;

  logic [DivW-1:0]                div_inc;
  logic                           div_hit;
  logic [prt_pkg::PRESCALE_W-1:0] pre_inc;
  logic [prt_pkg::PRESCALE_W-1:0] pre_limit;
  logic                           pre_hit;
  logic [prt_pkg::EXP_W-1:0]      exponent;
  logic [1:0]                     word;
  logic                           size_ok;

  assign word     = item_i.address_offset[3:2];
  assign size_ok  = (item_i.access_size == prt_pkg::ACCESS_SIZE_WORD);
  assign exponent = ctrl_q[prt_pkg::CTRL_EXP_LSB +: prt_pkg::EXP_W];

  assign div_inc   = div_q + DivW'(1);
  assign div_hit   = cfg_i.cpu_speed || (div_inc >= DivW'(SLOW_CLOCK_DIVIDE));
  assign pre_limit = prt_pkg::PRESCALE_W'(2) << exponent;
  assign pre_inc   = pre_q + prt_pkg::PRESCALE_W'(1);
  assign pre_hit   = (pre_inc >= pre_limit);

  always_comb begin
    ctrl_d   = ctrl_q;
    count_d  = count_q;
    load_d   = load_q;
    pre_d    = pre_q;
    div_d    = div_q;
    result_o = '0;

    if (item_i.action == prt_pkg::ACT_TICK) begin
      result_o.access_ok = 1'b1;
      if (ctrl_q[prt_pkg::CTRL_START_BIT]) begin
        div_d = div_hit ? '0 : div_inc;
        if (div_hit) begin
          pre_d = pre_hit ? '0 : pre_inc;
          if (pre_hit) begin
            if (count_q != '0) begin
              count_d = count_q - prt_pkg::DATA_W'(1);
            end else begin
              // expiry: reload or stop
              if (ctrl_q[prt_pkg::CTRL_RELOAD_BIT]) begin
                count_d = load_q;
              end else begin
                ctrl_d[prt_pkg::CTRL_START_BIT] = 1'b0;
              end
              result_o.irq_pulse = cfg_i.irq_connected;
            end
          end
        end
      end
    end else if ((item_i.action == prt_pkg::ACT_READ ||
                  item_i.action == prt_pkg::ACT_WRITE) && size_ok) begin
      unique case (word)
        prt_pkg::WORD_CTRL: begin
          result_o.access_ok = 1'b1;
          if (item_i.action == prt_pkg::ACT_WRITE) begin
            if (!ctrl_q[prt_pkg::CTRL_START_BIT] &&
                item_i.write_data[prt_pkg::CTRL_START_BIT]) begin
              count_d = load_q;
            end
            ctrl_d = item_i.write_data[prt_pkg::CTRL_W-1:0];
          end else begin
            result_o.read_data = prt_pkg::DATA_W'(ctrl_q);
          end
        end
        prt_pkg::WORD_LOAD: begin
          if (item_i.action == prt_pkg::ACT_WRITE) begin
            load_d             = item_i.write_data;
            result_o.access_ok = 1'b1;
          end
        end
        prt_pkg::WORD_COUNT: begin
          if (item_i.action == prt_pkg::ACT_READ) begin
            result_o.read_data = count_q;
            result_o.access_ok = 1'b1;
          end
        end
        default: begin
          result_o.access_ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      count_q <= '0;
      load_q  <= '0;
      pre_q   <= '0;
      div_q   <= '0;
    end else if (fire_i) begin
      ctrl_q  <= ctrl_d;
      count_q <= count_d;
      load_q  <= load_d;
      pre_q   <= pre_d;
      div_q   <= div_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/prescaled_reload_timer.sv -----
// an item's result is registered, shown in the cycle after its transfer
// throughput: one item per cycle; all state updates in the transfer cycle
// the result register frees as its own result is taken, so input stalls
// only while a result waits on a stalled output
// reset: asynchronous, active low; clears timer state, result valid and
// configuration (cpu speed off, interrupt connected)
`default_nettype none

module prescaled_reload_timer #(
  parameter int unsigned SLOW_CLOCK_DIVIDE = prt_pkg::SLOW_CLOCK_DIVIDE_DEFAULT
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_idx_i,
  input  wire logic   cfg_data_i,
  prt_stream_if.sink   item_i,
  prt_stream_if.source result_o
);

  prt_pkg::cfg_t    cfg_q;
  prt_pkg::result_t result_d;
  prt_pkg::result_t result_q;
  logic             valid_q;
  logic             fire;

  assign item_i.ready     = !valid_q || result_o.ready;
  assign fire             = item_i.valid && item_i.ready;
  assign result_o.valid   = valid_q;
  assign result_o.payload = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpu_speed     <= 1'b0;
      cfg_q.irq_connected <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        prt_pkg::CFG_CPU_SPEED:     cfg_q.cpu_speed     <= cfg_data_i;
        prt_pkg::CFG_IRQ_CONNECTED: cfg_q.irq_connected <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  prt_core #(
    .SLOW_CLOCK_DIVIDE(SLOW_CLOCK_DIVIDE)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (item_i.payload),
    .cfg_i   (cfg_q),
    .result_o(result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire) begin
      valid_q <= 1'b1;
    end else if (result_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

endmodule

`default_nettype wire
